[rtl/core/spc_pkg.sv]
// Shared package of the segment/particle collision unit.
// Holds field widths, arithmetic constants and the transaction payload types.
// No dependencies.
package spc_pkg;

	// Default number of fraction bits of positions, velocity and impulse.
	localparam int FRAC_BITS_DEF = 16;

	// Field widths of the payloads.
	localparam int COORD_W = 20;
	localparam int MASS_W  = 16;
	localparam int IMP_W   = 32;

	// Mass carries this many fraction bits.
	localparam int MASS_FRAC = 8;

	// Quotient bits of the impulse division; the quotient stays below 2^37.
	localparam int IMP_Q_W = 38;

	// Division by ten as a multiply by a rounded-up reciprocal and a shift.
	// Exact for every dividend below 2^26.
	localparam int             RECIP_SHIFT = 28;
	localparam int             RECIP_W     = 25;
	localparam logic [24:0]    RECIP_TENTH = 25'd26843546;

	// One bone/particle pair.
	typedef struct packed {
		logic signed [COORD_W-1:0] bone_start_x;
		logic signed [COORD_W-1:0] bone_start_y;
		logic signed [COORD_W-1:0] bone_end_x;
		logic signed [COORD_W-1:0] bone_end_y;
		logic signed [COORD_W-1:0] prev_x;
		logic signed [COORD_W-1:0] prev_y;
		logic signed [COORD_W-1:0] cur_x;
		logic signed [COORD_W-1:0] cur_y;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
		logic        [MASS_W-1:0]  mass;
	} spc_in_t;

	// Collision result of one pair.
	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] new_x;
		logic signed [COORD_W-1:0] new_y;
		logic signed [IMP_W-1:0]   impulse_x;
		logic signed [IMP_W-1:0]   impulse_y;
	} spc_out_t;

endpackage

[rtl/core/spc_in_if.sv]
// Input channel of the segment/particle collision unit.
// Carries valid, ready and one spc_pkg::spc_in_t payload.
interface spc_in_if;
	logic             valid;
	logic             ready;
	spc_pkg::spc_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/spc_out_if.sv]
// Output channel of the segment/particle collision unit.
// Carries valid, ready and one spc_pkg::spc_out_t payload.
interface spc_out_if;
	logic              valid;
	logic              ready;
	spc_pkg::spc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/segment_particle_collision_unit.sv]
// Segment/particle collision unit: takes one bone/particle pair per clock and returns
// hit, corrected position and impulse of each accepted pair. The pipeline has 50 register
// stages: 8 for differences, cross products, the hit decision and the impulse numerator,
// 38 long-division stages that resolve one quotient bit each for both impulse components
// and, in the first U_BITS of them, for the intersection parameter u, and 4 for the
// position correction. Throughput is one pair per cycle; the whole pipeline holds while
// a result sits untaken in the output register, so in_ch.ready follows out_ch.ready then.
// Depends on spc_pkg, spc_in_if and spc_out_if.
module segment_particle_collision_unit #(
	parameter int FRAC_BITS = spc_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spc_in_if.sink    in_ch,
	spc_out_if.source out_ch
);
	import spc_pkg::*;

	localparam int U_BITS = FRAC_BITS + 14;
	localparam int NDIV   = IMP_Q_W;
	localparam int PXW    = U_BITS + 22;
	localparam int YSW    = U_BITS + 26;

	// Geometry that rides along to the position correction.
	typedef struct packed {
		logic signed [19:0] ax;
		logic signed [19:0] ay;
		logic signed [19:0] bx;
		logic signed [19:0] by;
		logic signed [20:0] sx;
		logic signed [20:0] sy;
	} geo_t;

	// State of one long-division stage.
	typedef struct packed {
		geo_t                g;
		logic                hit;
		logic                neg_x;
		logic                neg_y;
		logic                u_eq;
		logic [41:0]         ud;
		logic [41:0]         u_rem;
		logic [U_BITS-1:0]   u_q;
		logic [41:0]         l2;
		logic [41:0]         ix_rem;
		logic [IMP_Q_W-1:0]  ix_num;
		logic [IMP_Q_W-1:0]  ix_q;
		logic [41:0]         iy_rem;
		logic [IMP_Q_W-1:0]  iy_num;
		logic [IMP_Q_W-1:0]  iy_q;
	} dstage_t;

	// One restoring division step: quotient bit on top, new remainder below.
	function automatic logic [42:0] div_step(input logic [41:0] rem, input logic nb,
			input logic [41:0] dvs);
		logic [42:0] t;
		begin
			t = {rem, nb};
			if (t >= {1'b0, dvs}) begin
				div_step = {1'b1, 42'(t - {1'b0, dvs})};
			end else begin
				div_step = {1'b0, t[41:0]};
			end
		end
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic dv_v [0:NDIV];
	logic v_s9, v_s10, v_s11, v_s12;

	// The pipeline advances unless the output register is held.
	assign en          = !v_s12 || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: coordinate differences.
	logic signed [20:0] rx_s1, ry_s1, qx_s1, qy_s1, ex_s1, ey_s1;
	logic signed [19:0] vx_s1, vy_s1;
	logic [15:0]        m_s1;
	geo_t               g_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1   <= 21'(in_ch.data.bone_end_x) - 21'(in_ch.data.bone_start_x);
			ry_s1   <= 21'(in_ch.data.bone_end_y) - 21'(in_ch.data.bone_start_y);
			qx_s1   <= 21'(in_ch.data.prev_x) - 21'(in_ch.data.bone_start_x);
			qy_s1   <= 21'(in_ch.data.prev_y) - 21'(in_ch.data.bone_start_y);
			ex_s1   <= 21'(in_ch.data.cur_x) - 21'(in_ch.data.bone_start_x);
			ey_s1   <= 21'(in_ch.data.cur_y) - 21'(in_ch.data.bone_start_y);
			vx_s1   <= in_ch.data.vel_x;
			vy_s1   <= in_ch.data.vel_y;
			m_s1    <= in_ch.data.mass;
			g_s1.ax <= in_ch.data.prev_x;
			g_s1.ay <= in_ch.data.prev_y;
			g_s1.bx <= in_ch.data.cur_x;
			g_s1.by <= in_ch.data.cur_y;
			g_s1.sx <= 21'(in_ch.data.cur_x) - 21'(in_ch.data.prev_x);
			g_s1.sy <= 21'(in_ch.data.cur_y) - 21'(in_ch.data.prev_y);
		end
	end

	// Stage 2: all cross-product terms.
	logic signed [41:0] sa1_s2, sa2_s2, sb1_s2, sb2_s2, d1_s2, d2_s2, t1_s2, t2_s2;
	logic signed [41:0] lx_s2, ly_s2, w1_s2, w2_s2;
	logic signed [20:0] rx_s2, ry_s2;
	logic [15:0]        m_s2;
	geo_t               g_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sa1_s2 <= ry_s1 * qx_s1;
			sa2_s2 <= rx_s1 * qy_s1;
			sb1_s2 <= ry_s1 * ex_s1;
			sb2_s2 <= rx_s1 * ey_s1;
			d1_s2  <= rx_s1 * g_s1.sy;
			d2_s2  <= ry_s1 * g_s1.sx;
			t1_s2  <= qx_s1 * g_s1.sy;
			t2_s2  <= qy_s1 * g_s1.sx;
			lx_s2  <= rx_s1 * rx_s1;
			ly_s2  <= ry_s1 * ry_s1;
			w1_s2  <= ry_s1 * 21'(vx_s1);
			w2_s2  <= rx_s1 * 21'(vy_s1);
			rx_s2  <= rx_s1;
			ry_s2  <= ry_s1;
			m_s2   <= m_s1;
			g_s2   <= g_s1;
		end
	end

	// Stage 3: side tests, denominator, numerators, squared length, normal dot velocity.
	logic signed [42:0] sa_s3, sb_s3, d_s3, tn_s3;
	logic signed [41:0] w_s3;
	logic [41:0]        l2_s3;
	logic signed [20:0] rx_s3, ry_s3;
	logic [15:0]        m_s3;
	geo_t               g_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s3 <= 43'(sa1_s2) - 43'(sa2_s2);
			sb_s3 <= 43'(sb1_s2) - 43'(sb2_s2);
			d_s3  <= 43'(d1_s2) - 43'(d2_s2);
			tn_s3 <= 43'(t1_s2) - 43'(t2_s2);
			w_s3  <= w1_s2 - w2_s2;
			l2_s3 <= 42'($unsigned(lx_s2)) + 42'($unsigned(ly_s2));
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;
			m_s3  <= m_s2;
			g_s3  <= g_s2;
		end
	end

	// Stage 4: hit decision with the denominator made positive.
	logic               same_c, dneg_c, hit_c;
	logic signed [42:0] dm_c, tm_c, um_c;

	always_comb begin
		same_c = (sa_s3 > 0 && sb_s3 > 0) || (sa_s3 < 0 && sb_s3 < 0);
		dneg_c = d_s3 < 0;
		dm_c   = dneg_c ? -d_s3 : d_s3;
		tm_c   = dneg_c ? -tn_s3 : tn_s3;
		um_c   = dneg_c ? -sa_s3 : sa_s3;
		hit_c  = (l2_s3 != '0) && !same_c && (d_s3 != '0) && (tm_c >= 0) &&
			(tm_c <= dm_c) && (um_c >= 0) && (um_c <= dm_c);
	end

	logic        hit_s4, nx_s4, ny_s4;
	logic [41:0] ud_s4, un_s4, w_s4, l2_s4;
	logic [20:0] mcx_s4, mcy_s4;
	logic [15:0] m_s4;
	geo_t        g_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= hit_c;
			ud_s4  <= dm_c[41:0];
			un_s4  <= um_c[41:0];
			w_s4   <= (w_s3 < 0) ? 42'(-w_s3) : 42'(w_s3);
			l2_s4  <= l2_s3;
			mcx_s4 <= (ry_s3 < 0) ? 21'(-ry_s3) : 21'(ry_s3);
			mcy_s4 <= (rx_s3 < 0) ? 21'(-rx_s3) : 21'(rx_s3);
			nx_s4  <= ry_s3 < 0;
			ny_s4  <= rx_s3 > 0;
			m_s4   <= m_s3;
			g_s4   <= g_s3;
		end
	end

	// Stage 5: partial products of |N.v| times each normal component.
	logic [41:0] pxl_s5, pxh_s5, pyl_s5, pyh_s5;
	logic        hit_s5, nx_s5, ny_s5;
	logic [41:0] ud_s5, un_s5, l2_s5;
	logic [15:0] m_s5;
	geo_t        g_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			pxl_s5 <= 42'(w_s4[20:0]) * 42'(mcx_s4);
			pxh_s5 <= 42'(w_s4[41:21]) * 42'(mcx_s4);
			pyl_s5 <= 42'(w_s4[20:0]) * 42'(mcy_s4);
			pyh_s5 <= 42'(w_s4[41:21]) * 42'(mcy_s4);
			hit_s5 <= hit_s4;
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			ud_s5  <= ud_s4;
			un_s5  <= un_s4;
			l2_s5  <= l2_s4;
			m_s5   <= m_s4;
			g_s5   <= g_s4;
		end
	end

	// Stage 6: combine the partial products.
	logic [62:0] xx_s6, xy_s6;
	logic        hit_s6, nx_s6, ny_s6;
	logic [41:0] ud_s6, un_s6, l2_s6;
	logic [15:0] m_s6;
	geo_t        g_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s6  <= {pxh_s5[41:0], 21'd0} + 63'(pxl_s5);
			xy_s6  <= {pyh_s5[41:0], 21'd0} + 63'(pyl_s5);
			hit_s6 <= hit_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			ud_s6  <= ud_s5;
			un_s6  <= un_s5;
			l2_s6  <= l2_s5;
			m_s6   <= m_s5;
			g_s6   <= g_s5;
		end
	end

	// Stage 7: multiply by mass in two halves.
	logic [47:0] mxl_s7, myl_s7;
	logic [46:0] mxh_s7, myh_s7;
	logic        hit_s7, nx_s7, ny_s7;
	logic [41:0] ud_s7, un_s7, l2_s7;
	geo_t        g_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			mxl_s7 <= 48'(xx_s6[31:0]) * 48'(m_s6);
			mxh_s7 <= 47'(xx_s6[62:32]) * 47'(m_s6);
			myl_s7 <= 48'(xy_s6[31:0]) * 48'(m_s6);
			myh_s7 <= 47'(xy_s6[62:32]) * 47'(m_s6);
			hit_s7 <= hit_s6;
			nx_s7  <= nx_s6;
			ny_s7  <= ny_s6;
			ud_s7  <= ud_s6;
			un_s7  <= un_s6;
			l2_s7  <= l2_s6;
			g_s7   <= g_s6;
		end
	end

	// Stage 8: doubled impulse numerators, loaded into the head of the divider chain.
	logic [78:0] nsx_c, nsy_c;
	logic [79:0] numx_c, numy_c;
	dstage_t     div_s [0:NDIV];

	always_comb begin
		nsx_c  = {mxh_s7, 32'd0} + 79'(mxl_s7);
		nsy_c  = {myh_s7, 32'd0} + 79'(myl_s7);
		numx_c = {nsx_c, 1'b0};
		numy_c = {nsy_c, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].g      <= g_s7;
			div_s[0].hit    <= hit_s7;
			div_s[0].neg_x  <= nx_s7;
			div_s[0].neg_y  <= ny_s7;
			div_s[0].u_eq   <= un_s7 == ud_s7;
			div_s[0].ud     <= ud_s7;
			div_s[0].u_rem  <= un_s7;
			div_s[0].u_q    <= '0;
			div_s[0].l2     <= l2_s7;
			div_s[0].ix_rem <= numx_c[79:IMP_Q_W];
			div_s[0].ix_num <= numx_c[IMP_Q_W-1:0];
			div_s[0].ix_q   <= '0;
			div_s[0].iy_rem <= numy_c[79:IMP_Q_W];
			div_s[0].iy_num <= numy_c[IMP_Q_W-1:0];
			div_s[0].iy_q   <= '0;
		end
	end

	// Divider chain: one quotient bit per stage for each impulse component,
	// and for u in the first U_BITS stages.
	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		logic [42:0] stx, sty, stu;
		dstage_t     nxt;

		always_comb begin
			stx = div_step(div_s[k-1].ix_rem, div_s[k-1].ix_num[IMP_Q_W-1], div_s[k-1].l2);
			sty = div_step(div_s[k-1].iy_rem, div_s[k-1].iy_num[IMP_Q_W-1], div_s[k-1].l2);
			stu = div_step(div_s[k-1].u_rem, 1'b0, div_s[k-1].ud);
			nxt        = div_s[k-1];
			nxt.ix_rem = stx[41:0];
			nxt.ix_num = {div_s[k-1].ix_num[IMP_Q_W-2:0], 1'b0};
			nxt.ix_q   = {div_s[k-1].ix_q[IMP_Q_W-2:0], stx[42]};
			nxt.iy_rem = sty[41:0];
			nxt.iy_num = {div_s[k-1].iy_num[IMP_Q_W-2:0], 1'b0};
			nxt.iy_q   = {div_s[k-1].iy_q[IMP_Q_W-2:0], sty[42]};
			if (k <= U_BITS) begin
				nxt.u_rem = stu[41:0];
				nxt.u_q   = {div_s[k-1].u_q[U_BITS-2:0], stu[42]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k] <= 1'b0;
			end else if (en) begin
				dv_v[k] <= dv_v[k-1];
			end
		end
	end

	// Stage 9: |s| times u, and rounding plus sign of the impulse components.
	// The rounded magnitude stays below 2^31, so the signed range is never exceeded.
	logic [U_BITS:0] uq_c;
	logic [20:0]     asx_c, asy_c;
	logic [38:0]     rx_c, ry_c;

	always_comb begin
		uq_c  = div_s[NDIV].u_eq ? ((U_BITS+1)'(1) << U_BITS) : {1'b0, div_s[NDIV].u_q};
		asx_c = (div_s[NDIV].g.sx < 0) ? 21'(-div_s[NDIV].g.sx) : 21'(div_s[NDIV].g.sx);
		asy_c = (div_s[NDIV].g.sy < 0) ? 21'(-div_s[NDIV].g.sy) : 21'(div_s[NDIV].g.sy);
		rx_c  = 39'(div_s[NDIV].ix_q) + 39'(1 << (MASS_FRAC - 1));
		ry_c  = 39'(div_s[NDIV].iy_q) + 39'(1 << (MASS_FRAC - 1));
	end

	logic [PXW-1:0]   px_s9, py_s9;
	logic signed [31:0] ix_s9, iy_s9;
	logic             hit_s9;
	geo_t             g_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s9  <= PXW'(asx_c) * PXW'(uq_c);
			py_s9  <= PXW'(asy_c) * PXW'(uq_c);
			hit_s9 <= div_s[NDIV].hit;
			g_s9   <= div_s[NDIV].g;
			if (!div_s[NDIV].hit) begin
				ix_s9 <= '0;
				iy_s9 <= '0;
			end else begin
				ix_s9 <= div_s[NDIV].neg_x ? -{1'b0, rx_c[38:MASS_FRAC]} :
					{1'b0, rx_c[38:MASS_FRAC]};
				iy_s9 <= div_s[NDIV].neg_y ? -{1'b0, ry_c[38:MASS_FRAC]} :
					{1'b0, ry_c[38:MASS_FRAC]};
			end
		end
	end

	// Stage 10: times nine plus a rounding offset of five units, truncated to whole units of the u scale.
	logic [YSW-1:0] ysx_c, ysy_c;

	always_comb begin
		ysx_c = YSW'(px_s9) + (YSW'(px_s9) << 3) + (YSW'(5) << U_BITS);
		ysy_c = YSW'(py_s9) + (YSW'(py_s9) << 3) + (YSW'(5) << U_BITS);
	end

	logic [23:0]        yx_s10, yy_s10;
	logic signed [31:0] ix_s10, iy_s10;
	logic               hit_s10;
	geo_t               g_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			yx_s10  <= ysx_c[U_BITS+23:U_BITS];
			yy_s10  <= ysy_c[U_BITS+23:U_BITS];
			ix_s10  <= ix_s9;
			iy_s10  <= iy_s9;
			hit_s10 <= hit_s9;
			g_s10   <= g_s9;
		end
	end

	// Stage 11: divide by ten through the reciprocal.
	logic [48:0]        zx_s11, zy_s11;
	logic signed [31:0] ix_s11, iy_s11;
	logic               hit_s11;
	geo_t               g_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			zx_s11  <= 49'(yx_s10) * 49'(RECIP_TENTH);
			zy_s11  <= 49'(yy_s10) * 49'(RECIP_TENTH);
			ix_s11  <= ix_s10;
			iy_s11  <= iy_s10;
			hit_s11 <= hit_s10;
			g_s11   <= g_s10;
		end
	end

	// Stage 12: apply the signed offset from the previous position; output register.
	logic [20:0] mx_c, my_c, cx_c, cy_c;

	always_comb begin
		mx_c = zx_s11[RECIP_SHIFT+20:RECIP_SHIFT];
		my_c = zy_s11[RECIP_SHIFT+20:RECIP_SHIFT];
		cx_c = (g_s11.sx < 0) ? 21'(g_s11.ax) - mx_c : 21'(g_s11.ax) + mx_c;
		cy_c = (g_s11.sy < 0) ? 21'(g_s11.ay) - my_c : 21'(g_s11.ay) + my_c;
	end

	spc_out_t res_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s12.hit       <= hit_s11;
			res_s12.new_x     <= hit_s11 ? cx_c[19:0] : g_s11.bx;
			res_s12.new_y     <= hit_s11 ? cy_c[19:0] : g_s11.by;
			res_s12.impulse_x <= ix_s11;
			res_s12.impulse_y <= iy_s11;
		end
	end

	assign out_ch.valid = v_s12;
	assign out_ch.data  = res_s12;

	// Valid bits of the stages outside the divider chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			dv_v[0] <= 1'b0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
			v_s11   <= 1'b0;
			v_s12   <= 1'b0;
		end else if (en) begin
			v_s1    <= in_ch.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			dv_v[0] <= v_s7;
			v_s9    <= dv_v[NDIV];
			v_s10   <= v_s9;
			v_s11   <= v_s10;
			v_s12   <= v_s11;
		end
	end

	// A result without a hit carries no impulse.
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.hit |->
		out_ch.data.impulse_x == '0 && out_ch.data.impulse_y == '0)
		else $error("impulse on a result without hit");

	// An accepted transaction enters the first stage.
	a_accept_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1)
		else $error("accepted transaction lost at stage 1");

	// While the pipeline holds, the valid bits do not move.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s9) && $stable(v_s12))
		else $error("valid bits moved during a stall");

	// A result that is taken frees the output register for the next stage.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !v_s11 |=> !out_ch.valid)
		else $error("result repeated after it was taken");

endmodule

[tb/tb_segment_particle_collision_unit.sv]
// Testbench of the segment/particle collision unit: streams bone/particle pairs with random
// idling on both channels and checks every result against a local fixed-point prediction.
// Depends on spc_pkg, spc_in_if, spc_out_if and segment_particle_collision_unit.
module tb_segment_particle_collision_unit;
	import spc_pkg::*;

	localparam int CMAX = 524287;
	localparam int CMIN = -524288;
	localparam int U_FRAC = FRAC_BITS_DEF + 14;
	localparam int PIPE_DEPTH = 50;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		spc_in_t pair;
		bit      drain_first;
	} pending_pair_t;

	logic clk;
	logic arst_n;

	spc_in_if  in_ch ();
	spc_out_if out_ch ();

	segment_particle_collision_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pending_pair_t pending_pairs[$];
	spc_out_t      expected_results[$];
	int            error_count = 0;
	int            pairs_taken = 0;
	int            send_gap = 0;
	int            recv_hold = 0;
	bit            long_hold_done = 1'b0;
	int            idle_cycles = 0;

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Appends one pair to the tail of the pending queue.
	function automatic void enqueue_pair(pending_pair_t pp);
		pending_pairs.insert(pending_pairs.size(), pp);
	endfunction

	// Rounded impulse component, saturated to the signed 32-bit range.
	function automatic logic [31:0] impulse_part(bit [63:0] w, longint c, bit [63:0] len2,
			bit [63:0] m);
		bit [63:0] mc, x, q, r, e, tot, mg;
		mc = (c < 0) ? 64'd0 - c : c;
		x = w * mc;
		q = x / len2;
		r = x % len2;
		e = (2 * m * r) / len2;
		tot = 2 * m * q + e;
		mg = (tot + (64'd1 << (MASS_FRAC - 1))) >> MASS_FRAC;
		if (c < 0) begin
			if (mg > 64'h8000_0000)
				mg = 64'h8000_0000;
			return 32'(64'd0 - mg);
		end
		if (mg > 64'h7FFF_FFFF)
			mg = 64'h7FFF_FFFF;
		return mg[31:0];
	endfunction

	// Expected collision result of one pair.
	function automatic spc_out_t predict_collision(spc_in_t p);
		longint p0x, p0y, p1x, p1y, ax, ay, bx, by, vx, vy;
		longint rx, ry, sx, sy, qx, qy, sa, sb, d, tn, un, nx, ny;
		bit [63:0] len2, ud, rem, uq, dv, mx, my, w, m;
		bit same;
		spc_out_t o;
		p0x = $signed(p.bone_start_x); p0y = $signed(p.bone_start_y);
		p1x = $signed(p.bone_end_x);   p1y = $signed(p.bone_end_y);
		ax = $signed(p.prev_x);        ay = $signed(p.prev_y);
		bx = $signed(p.cur_x);         by = $signed(p.cur_y);
		vx = $signed(p.vel_x);         vy = $signed(p.vel_y);
		m = 64'(p.mass);
		rx = p1x - p0x; ry = p1y - p0y;
		sx = bx - ax;   sy = by - ay;
		qx = ax - p0x;  qy = ay - p0y;
		o = '0;
		nx = bx; ny = by;
		len2 = rx * rx + ry * ry;
		if (len2 != 0) begin
			sa = ry * qx - rx * qy;
			sb = ry * (bx - p0x) - rx * (by - p0y);
			same = (sa > 0 && sb > 0) || (sa < 0 && sb < 0);
			d = rx * sy - ry * sx;
			if (!same && d != 0) begin
				tn = qx * sy - qy * sx;
				un = qx * ry - qy * rx;
				if (d < 0) begin
					d = -d; tn = -tn; un = -un;
				end
				if (tn >= 0 && tn <= d && un >= 0 && un <= d) begin
					o.hit = 1'b1;
					ud = d; rem = un; uq = '0;
					// u as a binary fraction by restoring division.
					if (rem == ud) begin
						uq = 64'd1 << U_FRAC;
					end else begin
						for (int i = 0; i < U_FRAC; i++) begin
							rem = rem << 1;
							uq = uq << 1;
							if (rem >= ud) begin
								rem = rem - ud;
								uq[0] = 1'b1;
							end
						end
					end
					dv = 64'd10 << U_FRAC;
					mx = ((sx < 0) ? -sx : sx);
					mx = (mx * uq * 9 + dv / 2) / dv;
					my = ((sy < 0) ? -sy : sy);
					my = (my * uq * 9 + dv / 2) / dv;
					nx = (sx < 0) ? ax - longint'(mx) : ax + longint'(mx);
					ny = (sy < 0) ? ay - longint'(my) : ay + longint'(my);
					w = ry * vx - rx * vy;
					if ($signed(w) < 0)
						w = 64'd0 - w;
					o.impulse_x = impulse_part(w, ry, len2, m);
					o.impulse_y = impulse_part(w, -rx, len2, m);
				end
			end
		end
		o.new_x = nx[COORD_W-1:0];
		o.new_y = ny[COORD_W-1:0];
		return o;
	endfunction

	function automatic spc_in_t make_pair(int p0x, int p0y, int p1x, int p1y, int ax, int ay,
			int bx, int by, int vx, int vy, int m);
		spc_in_t p;
		p.bone_start_x = COORD_W'(p0x); p.bone_start_y = COORD_W'(p0y);
		p.bone_end_x = COORD_W'(p1x);   p.bone_end_y = COORD_W'(p1y);
		p.prev_x = COORD_W'(ax);        p.prev_y = COORD_W'(ay);
		p.cur_x = COORD_W'(bx);         p.cur_y = COORD_W'(by);
		p.vel_x = COORD_W'(vx);         p.vel_y = COORD_W'(vy);
		p.mass = MASS_W'(m);
		return p;
	endfunction

	function automatic int rand_coord(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Motion that crosses a random bone, with random velocity and mass.
	function automatic spc_in_t make_crossing();
		int p0x, p0y, dx, dy, f, cx, cy, ex, ey, ka, kb;
		p0x = rand_coord(1 << 17); p0y = rand_coord(1 << 17);
		dx = rand_coord(1 << 16);  dy = rand_coord(1 << 16);
		if (dx == 0 && dy == 0)
			dx = 1;
		f = $urandom_range(1024);
		cx = p0x + (dx * f) / 1024; cy = p0y + (dy * f) / 1024;
		ex = rand_coord(1 << 15);  ey = rand_coord(1 << 15);
		ka = ($urandom_range(15) == 0) ? 0 : $urandom_range(1024);
		kb = ($urandom_range(15) == 0) ? 0 : $urandom_range(1024);
		return make_pair(p0x, p0y, p0x + dx, p0y + dy, cx - (ex * ka) / 1024,
			cy - (ey * ka) / 1024, cx + (ex * kb) / 1024, cy + (ey * kb) / 1024,
			$urandom, $urandom, $urandom);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Stimulus: directed corner cases, then a random mix.
	initial begin
		pending_pair_t pp;
		int kind;
		pp.drain_first = 0;
		pp.pair = make_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 65535);
		enqueue_pair(pp);
		pp.pair = make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0);
		enqueue_pair(pp);
		// Horizontal and vertical bones, plain crossings.
		pp.pair = make_pair(-65536, 0, 65536, 0, 0, 65536, 0, -65536, 0, -65536, 256);
		enqueue_pair(pp);
		pp.pair = make_pair(0, 65536, 0, -65536, -65536, 0, 65536, 0, 65536, 3, 512);
		enqueue_pair(pp);
		// Parallel motion, zero motion, and motion along the bone's line.
		pp.pair = make_pair(-65536, 0, 65536, 0, 0, 65536, 65536, 65536, 5, 5, 256);
		enqueue_pair(pp);
		pp.pair = make_pair(-65536, 0, 65536, 0, 0, 0, 0, 0, 5, 5, 256);
		enqueue_pair(pp);
		pp.pair = make_pair(-65536, 0, 65536, 0, -100, 0, 100, 0, 5, 5, 256);
		enqueue_pair(pp);
		// Previous position on the line, current position on the line.
		pp.pair = make_pair(-65536, 0, 65536, 0, 0, 0, 0, -65536, 7, -9, 300);
		enqueue_pair(pp);
		pp.pair = make_pair(-65536, 0, 65536, 0, 0, 65536, 0, 0, -7, 9, 300);
		enqueue_pair(pp);
		// Crossing exactly at either joint.
		pp.pair = make_pair(0, 0, 65536, 0, 0, 65536, 0, -65536, 1, -1, 1000);
		enqueue_pair(pp);
		pp.pair = make_pair(0, 0, 65536, 0, 65536, 65536, 65536, -65536, 1, -1, 1000);
		enqueue_pair(pp);
		// Past the end of the bone, and staying on one side.
		pp.pair = make_pair(-65536, 0, 65536, 0, 196608, 65536, 196608, -65536, 1, 1, 256);
		enqueue_pair(pp);
		pp.pair = make_pair(-65536, 0, 65536, 0, 0, 65536, 100, 30000, 1, 1, 256);
		enqueue_pair(pp);
		// Full-range diagonals and one full-range horizontal bone, with extreme velocity and mass.
		pp.pair = make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, 65535);
		enqueue_pair(pp);
		pp.pair = make_pair(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, 65535);
		enqueue_pair(pp);
		pp.pair = make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, 0);
		enqueue_pair(pp);
		pp.pair = make_pair(CMIN, 0, CMAX, 0, 0, CMAX, 0, CMIN, CMIN, CMAX, 32768);
		enqueue_pair(pp);
		for (int n = 0; n < 1800; n++) begin
			kind = $urandom_range(99);
			pp.drain_first = (n == 900);
			if (kind < 60) begin
				pp.pair = make_crossing();
			end else if (kind < 80) begin
				pp.pair = make_pair($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else if (kind < 95) begin
				pp.pair = make_pair(rand_coord(1024), rand_coord(1024), rand_coord(1024),
					rand_coord(1024), rand_coord(1024), rand_coord(1024), rand_coord(1024),
					rand_coord(1024), $urandom, $urandom, $urandom);
			end else begin
				pp.pair = make_crossing();
				if ($urandom_range(1)) begin
					pp.pair.bone_end_x = pp.pair.bone_start_x;
					pp.pair.bone_end_y = pp.pair.bone_start_y;
				end else begin
					pp.pair.cur_x = pp.pair.prev_x + pp.pair.bone_end_x - pp.pair.bone_start_x;
					pp.pair.cur_y = pp.pair.prev_y + pp.pair.bone_end_y - pp.pair.bone_start_y;
				end
			end
			enqueue_pair(pp);
		end
	end

	// Driver of the input channel.
	always @(posedge clk or negedge arst_n) begin
		pending_pair_t next_pair;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			send_gap <= 0;
		end else if (in_ch.valid && !in_ch.ready) begin
			// Hold the offered transaction.
		end else if (send_gap > 0) begin
			in_ch.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_pairs.size() > 0 && !(pending_pairs[0].drain_first &&
				(expected_results.size() > 0 || in_ch.valid))) begin
			next_pair = pending_pairs.pop_front();
			in_ch.valid <= 1'b1;
			in_ch.data <= next_pair.pair;
			send_gap <= ((pairs_taken / 150) % 3 == 0) ? 0 : pick_gap();
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Receiver readiness, with one long hold-off to fill the pipeline.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_hold <= 0;
		end else if (recv_hold > 0) begin
			out_ch.ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else if (!long_hold_done && pairs_taken >= 500) begin
			long_hold_done <= 1'b1;
			out_ch.ready <= 1'b0;
			recv_hold <= 300;
		end else if ((pairs_taken / 150) % 3 == 1) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= 1'b1;
			recv_hold <= pick_gap();
		end
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Monitor: predict on each input transaction, compare on each output transaction.
	always @(posedge clk) begin
		spc_out_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("result with nothing expected at %0t", $realtime);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_ch.data.hit !== want.hit)
						report_mismatch("hit", 64'(out_ch.data.hit), 64'(want.hit));
					if (out_ch.data.new_x !== want.new_x)
						report_mismatch("new_x", 64'(out_ch.data.new_x), 64'(want.new_x));
					if (out_ch.data.new_y !== want.new_y)
						report_mismatch("new_y", 64'(out_ch.data.new_y), 64'(want.new_y));
					if (out_ch.data.impulse_x !== want.impulse_x)
						report_mismatch("impulse_x", 64'(out_ch.data.impulse_x),
							64'(want.impulse_x));
					if (out_ch.data.impulse_y !== want.impulse_y)
						report_mismatch("impulse_y", 64'(out_ch.data.impulse_y),
							64'(want.impulse_y));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				expected_results.insert(expected_results.size(),
					predict_collision(in_ch.data));
				pairs_taken <= pairs_taken + 1;
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// End of run: the queues are checked between clock edges, once all updates settled.
	initial begin
		@(posedge arst_n);
		do
			@(negedge clk);
		while (pending_pairs.size() > 0 || in_ch.valid || expected_results.size() > 0);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[segment_particle_collision_unit.f]
rtl/core/spc_pkg.sv
rtl/core/spc_in_if.sv
rtl/core/spc_out_if.sv
rtl/core/segment_particle_collision_unit.sv
tb/tb_segment_particle_collision_unit.sv
